### sv/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg: shared types and constants for the duplicate-free FIFO
// Status codes, operation codes, sequencer states and response bundle.
// ----------------------------------------------------------------------------
package dfm_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int ITEM_WIDTH_DEF = 8;
	localparam int OCC_W          = 5;
	localparam int STATUS_W       = 3;

	localparam logic FUNC_PUT = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPENDED = 3'd0,
		ST_MOVED    = 3'd1,
		ST_GET_OK   = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GET,
		S_SCAN,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		status_t          status;
		logic [OCC_W-1:0] occ;
	} resp_t;

endpackage

### sv/dfm_ram.sv
// ----------------------------------------------------------------------------
// dfm_ram: item storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dfm_ram #(
	parameter int DEPTH      = 16,
	parameter int ITEM_WIDTH = 8,
	parameter int AW         = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [ITEM_WIDTH-1:0] wdata,
	input  logic [AW-1:0]         raddr,
	output logic [ITEM_WIDTH-1:0] rdata
);

	logic [ITEM_WIDTH-1:0] mem [DEPTH];
	logic [ITEM_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

### sv/dfm_seq.sv
// ----------------------------------------------------------------------------
// dfm_seq: sequencer with the shared item comparator
// Scans the ring one entry per cycle, closes the gap behind a match and
// writes the new tail; a get pops the head slot.
// ----------------------------------------------------------------------------
module dfm_seq
	import dfm_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ITEM_WIDTH = ITEM_WIDTH_DEF,
	parameter int AW         = $clog2(DEPTH),
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [ITEM_WIDTH-1:0] item,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [ITEM_WIDTH-1:0] ram_wdata,
	output logic [AW-1:0]         ram_raddr,
	input  logic [ITEM_WIDTH-1:0] ram_rdata,
	output logic                  res_valid,
	input  logic                  res_take,
	output logic [ITEM_WIDTH-1:0] res_item,
	output resp_t                 res
);

	seq_state_t            state_q, state_d;
	logic [AW-1:0]         head_q, head_d;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         rd_idx_q, rd_idx_d;
	logic                  cmp_vld_q, cmp_vld_d;
	logic                  found_q, found_d;
	logic [AW-1:0]         cmp_idx_q, cmp_idx_d;
	logic [ITEM_WIDTH-1:0] item_q, item_d;
	logic [ITEM_WIDTH-1:0] res_item_q, res_item_d;
	status_t               res_status_q, res_status_d;

	// ring address: base plus offset, wrapped once
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
			input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (AW + 1)'(DEPTH)) begin
			sum = sum - (AW + 1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			rd_idx_q  <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			rd_idx_q  <= rd_idx_d;
			cmp_vld_q <= cmp_vld_d;
			found_q   <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q    <= cmp_idx_d;
		item_q       <= item_d;
		res_item_q   <= res_item_d;
		res_status_q <= res_status_d;
	end

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		rd_idx_d     = rd_idx_q;
		cmp_vld_d    = cmp_vld_q;
		found_d      = found_q;
		cmp_idx_d    = cmp_idx_q;
		item_d       = item_q;
		res_item_d   = res_item_q;
		res_status_d = res_status_q;
		in_ready     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = head_q;
		ram_wdata    = item_q;
		ram_raddr    = head_q;
		res_valid    = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					item_d = item;
					if (func == FUNC_GET) begin
						if (count_q == '0) begin
							res_item_d   = '0;
							res_status_d = ST_EMPTY;
							state_d      = S_DONE;
						end else begin
							state_d = S_GET;
						end
					end else begin
						rd_idx_d  = '0;
						cmp_vld_d = 1'b0;
						found_d   = 1'b0;
						state_d   = S_SCAN;
					end
				end
			end
			S_GET: begin
				// head read was issued in the accept cycle
				res_item_d   = ram_rdata;
				res_status_d = ST_GET_OK;
				head_d       = phys(head_q, AW'(1));
				count_d      = count_q - CW'(1);
				state_d      = S_DONE;
			end
			S_SCAN: begin
				if (rd_idx_q < count_q) begin
					ram_raddr = phys(head_q, AW'(rd_idx_q));
					rd_idx_d  = rd_idx_q + CW'(1);
					cmp_vld_d = 1'b1;
					cmp_idx_d = AW'(rd_idx_q);
				end else begin
					cmp_vld_d = 1'b0;
				end
				if (cmp_vld_q) begin
					if (found_q) begin
						// shift entry down over the gap
						ram_we    = 1'b1;
						ram_waddr = phys(head_q, cmp_idx_q - AW'(1));
						ram_wdata = ram_rdata;
					end else if (ram_rdata == item_q) begin
						found_d = 1'b1;
					end
				end else if (rd_idx_q >= count_q) begin
					res_item_d = '0;
					state_d    = S_DONE;
					if (found_q) begin
						ram_we       = 1'b1;
						ram_waddr    = phys(head_q, AW'(count_q - CW'(1)));
						res_status_d = ST_MOVED;
					end else if (count_q == CW'(DEPTH)) begin
						res_status_d = ST_FULL;
					end else begin
						ram_we       = 1'b1;
						ram_waddr    = phys(head_q, AW'(count_q));
						count_d      = count_q + CW'(1);
						res_status_d = ST_APPENDED;
					end
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_item   = res_item_q;
	assign res.status = res_status_q;
	assign res.occ    = OCC_W'(count_q);

endmodule

### sv/dedup_fifo_move_to_end_core.sv
// ----------------------------------------------------------------------------
// dedup_fifo_move_to_end_core: FIFO of items that never holds duplicates
// A put of a held item moves it to the tail; a new item is appended.
// ----------------------------------------------------------------------------
// Operation: a get reads the head slot; a put scans every held entry, one
//   per cycle, through the single read port of the item RAM.
// Throughput: one operation at a time; in_ready is high only while idle.
// Reset: arst_n clears occupancy, head pointer, sequencer and output valid;
//   RAM contents are not cleared and are read only after being written.
// ----------------------------------------------------------------------------
module dedup_fifo_move_to_end_core
	import dfm_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [ITEM_WIDTH-1:0] item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ITEM_WIDTH-1:0] got_item,
	output logic [STATUS_W-1:0]   status,
	output logic [OCC_W-1:0]      occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [ITEM_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [ITEM_WIDTH-1:0] ram_rdata;
	logic                  res_valid;
	logic                  res_take;
	logic [ITEM_WIDTH-1:0] res_item;
	resp_t                 res;

	logic                  out_valid_q;
	logic [ITEM_WIDTH-1:0] got_item_q;
	logic [STATUS_W-1:0]   status_q;
	logic [OCC_W-1:0]      occ_q;

	// Storage: ring buffer of DEPTH slots, addressed relative to the head.
	dfm_ram #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH),
		.AW         (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: owns head and occupancy, runs the compare/compact scan.
	dfm_seq #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH),
		.AW         (AW),
		.CW         (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.item      (item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_item  (res_item),
		.res       (res)
	);

	// Output register: take a new result whenever the slot is empty or
	// being drained in this cycle; otherwise hold the sequencer in its
	// done state until the consumer frees the slot.
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load payload together with valid; no reset needed.
	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			got_item_q <= res_item;
			status_q   <= res.status;
			occ_q      <= res.occ;
		end
	end

	assign out_valid = out_valid_q;
	assign got_item  = got_item_q;
	assign status    = status_q;
	assign occupancy = occ_q;

endmodule

### sv/dfm_checker.sv
// ----------------------------------------------------------------------------
// dfm_checker: port-level assertions for the duplicate-free FIFO
// Checks result consistency and the one-item-at-a-time input behavior.
// ----------------------------------------------------------------------------
module dfm_checker
	import dfm_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [ITEM_WIDTH-1:0] got_item,
	input logic [STATUS_W-1:0]   status,
	input logic [OCC_W-1:0]      occupancy
);

	// drop ready in the cycle after an accepted item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready held high after accepting an item");

	// only a successful get returns a nonzero item
	a_item_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_GET_OK) |-> (got_item == '0))
		else $error("nonzero got_item on a non-get result");

	// an empty get reports an empty queue
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (occupancy == '0))
		else $error("empty status with nonzero occupancy");

	// a dropped put reports a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (occupancy == OCC_W'(DEPTH)))
		else $error("full status without full occupancy");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(got_item) && $stable(status) && $stable(occupancy)))
		else $error("result changed while stalled");

endmodule

bind dedup_fifo_move_to_end_core dfm_checker #(
	.DEPTH      (DEPTH),
	.ITEM_WIDTH (ITEM_WIDTH)
) u_dfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.got_item  (got_item),
	.status    (status),
	.occupancy (occupancy)
);

### bench/tb_dedup_fifo_move_to_end_core.sv
// ----------------------------------------------------------------------------
// tb_dedup_fifo_move_to_end_core: self-checking bench for the duplicate-free FIFO
// Drives puts and gets over valid/ready, predicts every response with an
// internal queue model and compares got_item, status and occupancy in order.
// ----------------------------------------------------------------------------
module tb_dedup_fifo_move_to_end_core;
	import dfm_pkg::*;

	localparam int IW = ITEM_WIDTH_DEF;

	// One predicted response of the block
	typedef struct {
		logic [IW-1:0]    got;
		status_t          st;
		logic [OCC_W-1:0] occ;
	} fifo_result_t;

	// Queue model plus the list of responses still owed by the block
	class fifo_scoreboard;
		logic [IW-1:0] held_items[$];
		fifo_result_t  awaited_results[$];
		int            errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// Apply one accepted operation to the model and queue its response
		function void apply_op(logic op, logic [IW-1:0] value);
			fifo_result_t res;
			int           pos;
			res.got = '0;
			pos = -1;
			if (op == FUNC_GET) begin
				if (held_items.size() == 0) begin
					res.st = ST_EMPTY;
				end else begin
					res.got = held_items.pop_front();
					res.st  = ST_GET_OK;
				end
			end else begin
				foreach (held_items[k])
					if (pos < 0 && held_items[k] == value)
						pos = k;
				if (pos >= 0) begin
					held_items.delete(pos);
					held_items.push_back(value);
					res.st = ST_MOVED;
				end else if (held_items.size() >= DEPTH_DEF) begin
					res.st = ST_FULL;
				end else begin
					held_items.push_back(value);
					res.st = ST_APPENDED;
				end
			end
			res.occ = OCC_W'(held_items.size());
			awaited_results.push_back(res);
		endfunction

		// Compare one delivered response with the oldest prediction
		function void check_result(logic [IW-1:0] got, logic [STATUS_W-1:0] st,
		                           logic [OCC_W-1:0] occ);
			fifo_result_t want;
			if (awaited_results.size() == 0) begin
				$error("unexpected response: got_item %0h status %0d occupancy %0d",
				       got, st, occ);
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			if (got !== want.got) begin
				$error("got_item: expected %0h, actual %0h", want.got, got);
				errors++;
			end
			if (st !== want.st) begin
				$error("status: expected %0d, actual %0d", want.st, st);
				errors++;
			end
			if (occ !== want.occ) begin
				$error("occupancy: expected %0d, actual %0d", want.occ, occ);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                func = FUNC_PUT;
	logic [IW-1:0]       item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [IW-1:0]       got_item;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;

	// Idle rates in percent for the sender and the receiver
	int send_idle = 0;
	int recv_idle = 0;

	fifo_scoreboard board = new();

	dedup_fifo_move_to_end_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.item     (item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.got_item (got_item),
		.status   (status),
		.occupancy(occupancy)
	);

	always #5 clk = ~clk;

	// Receiver: check each delivered response, then draw the next stall.
	// Values read here are the ones from before the edge, so a response
	// accepted at this edge is the one the block presented.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(got_item, status, occupancy);
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Present one operation, optionally after a random gap, and hold it
	// until the block takes it. Valid stays high on return so that a
	// back-to-back operation needs no second assignment in the same step.
	task automatic send_op(input logic op, input logic [IW-1:0] value);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		func     <= op;
		item     <= value;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.apply_op(op, value);
	endtask

	// Hold off the sender until every owed response has come back
	task automatic drain_pause();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() > 0);
	endtask

	// Random traffic. The put share changes every few dozen operations so the
	// queue swings between empty and full; values mostly come from a pool a
	// little larger than the depth, so moves and full drops are frequent.
	task automatic random_phase(input int count);
		int            put_pct;
		logic          op;
		logic [IW-1:0] value;
		put_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(3))
					0: put_pct = 25;
					1: put_pct = 50;
					2: put_pct = 75;
					default: put_pct = 92;
				endcase
			end
			if (i == count / 2)
				drain_pause();
			op = ($urandom_range(99) < put_pct) ? FUNC_PUT : FUNC_GET;
			if ($urandom_range(9) < 7)
				value = IW'($urandom_range(DEPTH_DEF + 7, 0));
			else
				value = IW'($urandom_range((1 << IW) - 1, 0));
			send_op(op, value);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 26;
		recv_idle = 55;

		// Get on an empty queue
		send_op(FUNC_GET, 8'h00);
		// Extreme and alternating bit patterns
		send_op(FUNC_PUT, 8'h00);
		send_op(FUNC_PUT, 8'hFF);
		send_op(FUNC_PUT, 8'hA5);
		send_op(FUNC_PUT, 8'h5A);
		// Duplicate of the head moves to the tail
		send_op(FUNC_PUT, 8'h00);
		// Fill to the top
		for (int v = 1; v <= DEPTH_DEF - 4; v++)
			send_op(FUNC_PUT, IW'(v));
		// New item into a full queue is dropped
		send_op(FUNC_PUT, 8'h80);
		// Held item into a full queue still moves to the tail
		send_op(FUNC_PUT, 8'hFF);
		// Gets return the head; the item field is ignored
		send_op(FUNC_GET, 8'h00);
		send_op(FUNC_GET, 8'hFF);

		random_phase(300);
		drain_pause();

		send_idle = 55;
		recv_idle = 26;
		random_phase(300);
		drain_pause();

		send_idle = 0;
		recv_idle = 0;
		random_phase(300);
		in_valid <= 1'b0;

		// Wait out the remaining responses, then let the clock run on
		while (board.pending() > 0) @(posedge clk);
		repeat (2 * DEPTH_DEF + 8) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
